### hdl/fmmn_pkg.sv
// ============================================================================
// fmmn_pkg
// Shared types and constants for the frame min-max normalizer.
// ============================================================================
package fmmn_pkg;

    // Width of the normalized result, unsigned Q0.16
    localparam int NORM_BITS    = 16;
    localparam int DIV_CNT_BITS = $clog2(NORM_BITS + 1);

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } opcode_t;

    // Controller to datapath
    typedef struct packed
    {
        logic load;       // store the incoming sample
        logic fetch;      // read the next stored sample, mark loading done
        logic capture;    // latch numerator and span
        logic div_start;  // launch the divider
        logic emit;       // write the result word and advance the frame
    } fmmn_cmd_t;

    // Datapath to controller
    typedef struct packed
    {
        logic empty;      // nothing stored in the frame
        logic div_busy;   // divider still iterating
        logic slot_free;  // output register can take a word this cycle
    } fmmn_status_t;

endpackage

### hdl/fmmn_in_if.sv
// ============================================================================
// fmmn_in_if
// Input channel: opcode and sample with valid/ready handshake.
// ============================================================================
interface fmmn_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source
    (
        output valid,
        output opcode,
        output sample,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  opcode,
        input  sample,
        output ready
    );
endinterface

### hdl/fmmn_out_if.sv
// ============================================================================
// fmmn_out_if
// Result channel: normalized sample and flags with valid/ready handshake.
// ============================================================================
interface fmmn_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] norm_value;
    logic        last_of_frame;
    logic        flat_frame;
    logic        nothing_stored;

    modport source
    (
        output valid,
        output norm_value,
        output last_of_frame,
        output flat_frame,
        output nothing_stored,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  norm_value,
        input  last_of_frame,
        input  flat_frame,
        input  nothing_stored,
        output ready
    );
endinterface

### hdl/fmmn_div.sv
// ============================================================================
// fmmn_div
// Bit-serial restoring divider: round(num * 65535 / den), one quotient bit
// per cycle. Requires num <= den.
// ============================================================================
module fmmn_div #(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [SAMPLE_BITS-1:0]              num,
    input  logic [SAMPLE_BITS-1:0]              den,
    output logic                                busy,
    output logic [fmmn_pkg::NORM_BITS-1:0]      quot
);
    import fmmn_pkg::*;

    localparam int DW = SAMPLE_BITS + NORM_BITS;

    logic [SAMPLE_BITS-1:0]  rem_reg;
    logic [SAMPLE_BITS-1:0]  den_reg;
    logic [NORM_BITS-1:0]    q_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic                    busy_reg;

    logic [DW-1:0]          dividend;
    logic [SAMPLE_BITS:0]   shifted;
    logic [SAMPLE_BITS:0]   diff;
    logic                   ge;

    // num * 65535 + den / 2, as (num << 16) - num + (den >> 1)
    assign dividend = {num, {NORM_BITS{1'b0}}} - {{NORM_BITS{1'b0}}, num}
                    + {{(NORM_BITS + 1){1'b0}}, den[SAMPLE_BITS-1:1]};

    assign shifted = {rem_reg, q_reg[NORM_BITS-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(NORM_BITS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Low dividend bits shift out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[DW-1:NORM_BITS];
            q_reg   <= dividend[NORM_BITS-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
            q_reg   <= {q_reg[NORM_BITS-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

### hdl/fmmn_datapath.sv
// ============================================================================
// fmmn_datapath
// Frame store, running min/max, frame pointers, divider and result register.
// ============================================================================
module fmmn_datapath #(
    parameter int FRAME_PIXELS = 4096,
    parameter int SAMPLE_BITS  = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fmmn_pkg::fmmn_cmd_t           cmd,
    output fmmn_pkg::fmmn_status_t        status,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    fmmn_out_if.source                    result_ch
);
    import fmmn_pkg::*;

    localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int CW = $clog2(FRAME_PIXELS + 1);

    logic signed [SAMPLE_BITS-1:0] mem [FRAME_PIXELS];

    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg;
    logic signed [SAMPLE_BITS-1:0] max_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 rptr_reg;
    logic                          done_reg;
    logic [SAMPLE_BITS-1:0]        num_reg;
    logic [SAMPLE_BITS-1:0]        den_reg;

    logic                          out_valid_reg;
    logic [NORM_BITS-1:0]          norm_reg;
    logic                          last_reg;
    logic                          flat_reg;
    logic                          empty_reg;

    logic                          store_en;
    logic                          empty;
    logic                          flat;
    logic                          last;
    logic                          frame_end;
    logic [SAMPLE_BITS:0]          num_diff;
    logic [SAMPLE_BITS:0]          den_diff;
    logic                          div_busy;
    logic [NORM_BITS-1:0]          quot;

    assign empty     = (count_reg == '0);
    assign store_en  = cmd.load && !done_reg && (count_reg < CW'(FRAME_PIXELS));
    assign flat      = (max_reg == min_reg);
    assign last      = (CW'(rptr_reg + CW'(1)) == count_reg);
    assign frame_end = cmd.emit && !empty && last;

    // Both differences are non-negative and fit the unsigned sample width
    assign num_diff = {rd_data_reg[SAMPLE_BITS-1], rd_data_reg}
                    - {min_reg[SAMPLE_BITS-1], min_reg};
    assign den_diff = {max_reg[SAMPLE_BITS-1], max_reg}
                    - {min_reg[SAMPLE_BITS-1], min_reg};

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[count_reg[AW-1:0]] <= sample;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= mem[rptr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= '0;
            max_reg   <= '0;
            count_reg <= '0;
            rptr_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else if (frame_end)
        begin
            min_reg   <= '0;
            max_reg   <= '0;
            count_reg <= '0;
            rptr_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (store_en)
            begin
                count_reg <= count_reg + CW'(1);
                if (empty)
                begin
                    min_reg <= sample;
                    max_reg <= sample;
                end
                else
                begin
                    if (sample < min_reg)
                    begin
                        min_reg <= sample;
                    end
                    if (sample > max_reg)
                    begin
                        max_reg <= sample;
                    end
                end
            end
            if (cmd.fetch)
            begin
                done_reg <= 1'b1;
            end
            if (cmd.emit && !empty)
            begin
                rptr_reg <= rptr_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            num_reg <= num_diff[SAMPLE_BITS-1:0];
            den_reg <= den_diff[SAMPLE_BITS-1:0];
        end
    end

    fmmn_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg),
        .den   (den_reg),
        .busy  (div_busy),
        .quot  (quot)
    );

    // Result register: hold the word until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (empty)
            begin
                norm_reg  <= '0;
                last_reg  <= 1'b0;
                flat_reg  <= 1'b0;
                empty_reg <= 1'b1;
            end
            else
            begin
                norm_reg  <= flat ? '0 : quot;
                last_reg  <= last;
                flat_reg  <= flat;
                empty_reg <= 1'b0;
            end
        end
    end

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.norm_value     = norm_reg;
    assign result_ch.last_of_frame  = last_reg;
    assign result_ch.flat_frame     = flat_reg;
    assign result_ch.nothing_stored = empty_reg;

    assign status.empty     = empty;
    assign status.div_busy  = div_busy;
    assign status.slot_free = !out_valid_reg || result_ch.ready;

endmodule

### hdl/fmmn_ctrl.sv
// ============================================================================
// fmmn_ctrl
// Sequencer: takes input words, steps a fetch through read, divide and emit.
// ============================================================================
module fmmn_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid,
    input  fmmn_pkg::opcode_t      opcode,
    output logic                   ready,
    input  fmmn_pkg::fmmn_status_t status,
    output fmmn_pkg::fmmn_cmd_t    cmd
);
    import fmmn_pkg::*;

    typedef enum logic [4:0]
    {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_PREP = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
                if (valid)
                begin
                    if (opcode == OP_FETCH)
                    begin
                        if (status.empty)
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            cmd.fetch  = 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                cmd.capture = 1'b1;
                state_next  = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // hold until the result register frees up
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/frame_min_max_normalizer_unit.sv
// ============================================================================
// frame_min_max_normalizer_unit
// Min-max normalization of one frame of signed samples to unsigned Q0.16.
// ============================================================================
// A load word stores one sample and updates the frame minimum and maximum;
// loads after the first fetch of a frame, or into a full store, are
// dropped. A fetch word returns the next stored sample as
// round((x - min) * 65535 / (max - min)); it occupies the block while it
// accepts the word and reads the frame store, forms the difference and
// span, loads the divider, runs the bit-serial divider and sees it
// finish, and writes the result register. The last step waits longer
// while the previous result word has not been taken. A fetch on an empty
// store goes straight to the result write with nothing_stored set. A flat
// frame returns 0 with flat_frame set. The final sample carries
// last_of_frame, and the frame clears itself right after it. A finished
// result waits in an output register while load words keep flowing. No
// clearing pass after reset: the store is only read below the fill count.
// ============================================================================
module frame_min_max_normalizer_unit #(
    parameter int FRAME_PIXELS = 4096,
    parameter int SAMPLE_BITS  = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    fmmn_in_if.sink    sample_ch,
    fmmn_out_if.source result_ch
);
    import fmmn_pkg::*;

    fmmn_cmd_t    cmd;
    fmmn_status_t status;
    logic         ready;

    assign sample_ch.ready = ready;

    fmmn_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (sample_ch.valid),
        .opcode (opcode_t'(sample_ch.opcode)),
        .ready  (ready),
        .status (status),
        .cmd    (cmd)
    );

    fmmn_datapath #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (sample_ch.sample),
        .result_ch (result_ch)
    );

    a_empty_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && result_ch.nothing_stored
        |-> result_ch.norm_value == '0 && !result_ch.last_of_frame
            && !result_ch.flat_frame)
        else $error("empty fetch word carries data");

    a_flat_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && result_ch.flat_frame |-> result_ch.norm_value == '0)
        else $error("flat frame word is not zero");

    a_fetch_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ch.valid && sample_ch.ready && sample_ch.opcode == OP_FETCH
        |=> !sample_ch.ready)
        else $error("input taken while a fetch is in progress");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> result_ch.valid)
        else $error("result word lost");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the frame min-max normalizer. Load and fetch words
// go in through the sample channel; a scoreboard model keeps its own frame
// store, running min/max and read pointer, predicts each normalized result
// and compares it field by field with what comes out of the result channel.
// Runs directed corner frames, random frames under several idling mixes and
// a long result stall that backs up the input.
// ============================================================================
module tb;
    import fmmn_pkg::*;

    localparam int FRAME_PIXELS = 4096;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_PRINTS   = 50;

    typedef enum int
    {
        MIX_WIDE,
        MIX_NARROW,
        MIX_FLAT,
        MIX_EXTREME
    } sample_mix_t;

    typedef struct packed
    {
        logic [15:0] norm_value;
        logic        last_of_frame;
        logic        flat_frame;
        logic        nothing_stored;
    } norm_result_t;

    logic clk;
    logic rst_n;

    fmmn_in_if #(.SAMPLE_BITS(16)) sample_ch ();
    fmmn_out_if                    result_ch ();

    frame_min_max_normalizer_unit #(
        .FRAME_PIXELS(FRAME_PIXELS),
        .SAMPLE_BITS (16)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample_ch(sample_ch),
        .result_ch(result_ch)
    );

    // Scoreboard model state
    logic signed [15:0] pixel_mem [FRAME_PIXELS];
    int                 frame_lo;
    int                 frame_hi;
    int unsigned        pixel_count;
    int unsigned        pixel_rd;
    bit                 fetch_begun;
    norm_result_t       norm_expected_q [$];

    int counted_words;
    int mismatch_count;
    int src_idle_pct;
    int sink_idle_pct;
    int hold_seq;
    int quiet_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void clear_frame_model();
        frame_lo    = 0;
        frame_hi    = 0;
        pixel_count = 0;
        pixel_rd    = 0;
        fetch_begun = 1'b0;
    endfunction

    // Update the model for one accepted word and queue the result it causes
    function automatic void apply_word(input opcode_t op, input logic signed [15:0] smp);
        norm_result_t      r;
        int                x;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   val;
        bit                is_last;
        if (op == OP_LOAD)
        begin
            // drop loads after the first fetch or into a full store
            if (fetch_begun || pixel_count >= FRAME_PIXELS)
                return;
            pixel_mem[pixel_count] = smp;
            if (pixel_count == 0)
            begin
                frame_lo = smp;
                frame_hi = smp;
            end
            else
            begin
                if (smp < frame_lo)
                    frame_lo = smp;
                if (smp > frame_hi)
                    frame_hi = smp;
            end
            pixel_count++;
            counted_words++;
            return;
        end
        counted_words++;
        r = '0;
        if (pixel_count == 0)
        begin
            r.nothing_stored = 1'b1;
            norm_expected_q.push_back(r);
            return;
        end
        fetch_begun = 1'b1;
        x = pixel_mem[pixel_rd];
        if (frame_hi == frame_lo)
            r.flat_frame = 1'b1;
        else
        begin
            den = longint'(frame_hi - frame_lo);
            num = longint'(x - frame_lo);
            val = (num * 65535 + den / 2) / den;
            if (val > 65535)
                val = 65535;
            r.norm_value = val[15:0];
        end
        is_last = (pixel_rd + 1 >= pixel_count);
        r.last_of_frame = is_last;
        norm_expected_q.push_back(r);
        if (is_last)
            clear_frame_model();
        else
            pixel_rd++;
    endfunction

    function automatic logic [15:0] pick_sample(input sample_mix_t mix, input logic [15:0] base);
        case (mix)
            MIX_WIDE:   return 16'($urandom);
            MIX_NARROW: return base + 16'($urandom_range(7));
            MIX_FLAT:   return base;
            default:
            begin
                case ($urandom_range(3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    // Enter and leave at a falling edge; valid stays high for a following word
    task automatic send_word(input opcode_t op, input logic [15:0] smp);
        while ($urandom_range(99) < src_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.opcode <= op;
        sample_ch.sample <= smp;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        sample_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (norm_expected_q.size() != 0);
    endtask

    // Load len samples, then fetch len times; stray loads may sneak in mid-fetch
    task automatic send_frame(input int len, input sample_mix_t mix, input bit stray_loads);
        logic [15:0] base;
        base = 16'($urandom);
        repeat (len)
            send_word(OP_LOAD, pick_sample(mix, base));
        for (int i = 0; i < len; i++)
        begin
            if (stray_loads && i > 0 && $urandom_range(9) == 0)
                send_word(OP_LOAD, 16'($urandom));
            send_word(OP_FETCH, 16'($urandom));
        end
        // one more fetch now and then to hit the empty store
        if (stray_loads && $urandom_range(9) == 0)
            send_word(OP_FETCH, 16'($urandom));
    endtask

    task automatic test_directed();
        src_idle_pct  = 0;
        sink_idle_pct = 30;
        send_word(OP_FETCH, 16'h0000);
        send_word(OP_LOAD, 16'h8000);
        send_word(OP_LOAD, 16'h7FFF);
        send_word(OP_LOAD, 16'h0000);
        send_word(OP_LOAD, 16'hFFFF);
        send_word(OP_LOAD, 16'h5555);
        send_word(OP_LOAD, 16'hAAAA);
        send_word(OP_FETCH, 16'h0000);
        // loads after fetching began must be dropped
        send_word(OP_LOAD, 16'h0064);
        repeat (5)
            send_word(OP_FETCH, 16'hFFFF);
        send_word(OP_FETCH, 16'h0000);
        repeat (3)
            send_word(OP_LOAD, 16'd1234);
        repeat (3)
            send_word(OP_FETCH, 16'h0000);
        send_word(OP_LOAD, 16'hFFF9);
        send_word(OP_FETCH, 16'h0000);
        wait_for_results();
    endtask

    task automatic test_random_frames(input int src_pct, input int sink_pct,
                                      input int word_goal);
        int goal_end;
        int len;
        int pick;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        goal_end      = counted_words + word_goal;
        while (counted_words < goal_end)
        begin
            pick = $urandom_range(99);
            if (pick < 85)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    len = $urandom_range(8, 1);
                else if (pick < 95)
                    len = $urandom_range(40, 9);
                else
                    len = $urandom_range(200, 41);
                send_frame(len, sample_mix_t'($urandom_range(3)), 1'b1);
            end
            else
            begin
                repeat ($urandom_range(6, 1))
                    send_word(opcode_t'($urandom_range(1)), 16'($urandom));
            end
        end
        wait_for_results();
    endtask

    task automatic test_output_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        @(posedge clk);
        hold_seq++;
        @(negedge clk);
        send_frame(24, MIX_WIDE, 1'b0);
        wait_for_results();
    endtask

    // Result receiver: random ready, or a long hold when requested
    initial
    begin
        int hold_left;
        int seen_seq;
        hold_left       = 0;
        seen_seq        = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != seen_seq)
            begin
                seen_seq  = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin : monitor
        norm_result_t got;
        norm_result_t want;
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
                apply_word(opcode_t'(sample_ch.opcode), sample_ch.sample);
            if (result_ch.valid && result_ch.ready)
            begin
                got = {result_ch.norm_value, result_ch.last_of_frame,
                       result_ch.flat_frame, result_ch.nothing_stored};
                if (norm_expected_q.size() == 0)
                    report_mismatch("unexpected result word", got, 0);
                else
                begin
                    want = norm_expected_q.pop_front();
                    if (got.norm_value !== want.norm_value)
                        report_mismatch("norm_value", got.norm_value, want.norm_value);
                    if (got.last_of_frame !== want.last_of_frame)
                        report_mismatch("last_of_frame", got.last_of_frame,
                                        want.last_of_frame);
                    if (got.flat_frame !== want.flat_frame)
                        report_mismatch("flat_frame", got.flat_frame, want.flat_frame);
                    if (got.nothing_stored !== want.nothing_stored)
                        report_mismatch("nothing_stored", got.nothing_stored,
                                        want.nothing_stored);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready)
            || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n            = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.opcode = OP_LOAD;
        sample_ch.sample = '0;
        counted_words    = 0;
        mismatch_count   = 0;
        src_idle_pct     = 0;
        sink_idle_pct    = 0;
        hold_seq         = 0;
        quiet_cycles     = 0;
        clear_frame_model();
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_frames(15, 88, 340);
        test_random_frames(88, 15, 340);
        test_random_frames(0, 0, 340);
        test_output_backpressure();

        repeat (TAIL_CYCLES)
            @(negedge clk);
        if (mismatch_count == 0 && norm_expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
